[src/lbg_pkg.sv]
`timescale 1ns / 1ps
// lbg_pkg: shared types, register indexes, reciprocal constants and palette tables
// for the LED bar gradient renderer. No dependencies.
package lbg_pkg;

	localparam int LED_COUNT_DEF = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 11;

	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_LOW   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_HUM_HIGH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT    = 3'd5;

	localparam int FULL_SCALE = 1000;

	// floor(x / 10000) for x < 2**21
	localparam logic [20:0] RCP_10K    = 21'd1717987;
	localparam int          RCP_10K_SH = 34;
	// floor(x / 1000) for x <= 64000
	localparam logic [16:0] RCP_1K_LO    = 17'd67109;
	localparam int          RCP_1K_LO_SH = 26;
	// floor(x / 1000) for x < 2**18
	localparam logic [18:0] RCP_1K    = 19'd268436;
	localparam int          RCP_1K_SH = 28;

	// channel 0 red, 1 green, 2 blue
	typedef logic [2:0][7:0] rgb_t;

	typedef struct packed {
		logic              quantity_mode;
		logic signed [10:0] temp_low_limit;
		logic signed [10:0] temp_high_limit;
		logic signed [10:0] hum_low_limit;
		logic signed [10:0] hum_high_limit;
		logic        [9:0]  brightness_permille;
	} cfg_t;

	typedef struct packed {
		logic [5:0] active;
		rgb_t       part;
	} frame_t;

	function automatic rgb_t mk_rgb(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		return {b, g, r};
	endfunction

	function automatic logic [2:0] pal_segs(input logic hum);
		return hum ? 3'd4 : 3'd3;
	endfunction

	function automatic rgb_t pal_color(input logic hum, input logic [2:0] idx);
		rgb_t c;
		c = '0;
		if (hum) begin
			unique case (idx)
				3'd0:    c = mk_rgb(8'd0,   8'd0, 8'd255);
				3'd1:    c = mk_rgb(8'd64,  8'd0, 8'd255);
				3'd2:    c = mk_rgb(8'd128, 8'd0, 8'd255);
				3'd3:    c = mk_rgb(8'd192, 8'd0, 8'd255);
				default: c = mk_rgb(8'd255, 8'd0, 8'd255);
			endcase
		end else begin
			unique case (idx)
				3'd0:    c = mk_rgb(8'd0,   8'd255, 8'd0);
				3'd1:    c = mk_rgb(8'd255, 8'd255, 8'd0);
				3'd2:    c = mk_rgb(8'd255, 8'd128, 8'd0);
				default: c = mk_rgb(8'd255, 8'd0,   8'd0);
			endcase
		end
		return c;
	endfunction

endpackage

[src/led_bar_gradient_renderer.sv]
`timescale 1ns / 1ps
// led_bar_gradient_renderer: top level with the configuration registers and stream ports.
// Depends on lbg_pkg, lbg_level and lbg_pixel.
//
// Each accepted reading (whole part and millionths) yields LED_COUNT pixels, led_index 0
// first, tlast on the final one. Readings flow through a 24-stage pipeline (reciprocal
// divide to hundredths, range check, 10-stage restoring divider for the fill level, then
// active LED and palette blend) and a 4-stage pixel pipeline that dims each channel. The
// output port carries one pixel per cycle while m_axis_tready is high; a new reading is
// taken while the previous frame is still streaming out. Write the configuration only
// while no frame is in flight.
module led_bar_gradient_renderer #(
	parameter int LED_COUNT = lbg_pkg::LED_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [31:0]                     s_axis_tdata,  // reading_whole, reading_micro
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [31:0]                     m_axis_tdata,  // led_index, red, green, blue
	output logic                            m_axis_tlast,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lbg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lbg_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lbg_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quantity_mode       <= 1'b0;
			cfg_q.temp_low_limit      <= 11'sd15;
			cfg_q.temp_high_limit     <= 11'sd35;
			cfg_q.hum_low_limit       <= 11'sd0;
			cfg_q.hum_high_limit      <= 11'sd100;
			cfg_q.brightness_permille <= 10'd100;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MODE:      cfg_q.quantity_mode       <= cfg_data[0];
				REG_TEMP_LOW:  cfg_q.temp_low_limit      <= cfg_data;
				REG_TEMP_HIGH: cfg_q.temp_high_limit     <= cfg_data;
				REG_HUM_LOW:   cfg_q.hum_low_limit       <= cfg_data;
				REG_HUM_HIGH:  cfg_q.hum_high_limit      <= cfg_data;
				REG_BRIGHT:    cfg_q.brightness_permille <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	logic   frame_valid;
	logic   frame_take;
	frame_t frame;

	lbg_level #(
		.LED_COUNT(LED_COUNT)
	) u_level (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.whole       ($signed(s_axis_tdata[10:0])),
		.micro       ($signed(s_axis_tdata[31:11])),
		.frame_valid (frame_valid),
		.frame_take  (frame_take),
		.frame       (frame)
	);

	logic [5:0] led_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	lbg_pixel #(
		.LED_COUNT(LED_COUNT)
	) u_pixel (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.frame_valid (frame_valid),
		.frame_take  (frame_take),
		.frame       (frame),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.led_index   (led_index),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.last_pixel  (m_axis_tlast)
	);

	assign m_axis_tdata = {2'b00, blue, green, red, led_index};

endmodule

[src/lbg_level.sv]
`timescale 1ns / 1ps
// lbg_level: per-reading pipeline, from reading to fill level, active LED and
// blended color of the active LED. Depends on lbg_pkg.
module lbg_level #(
	parameter int LED_COUNT = lbg_pkg::LED_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lbg_pkg::cfg_t      cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [10:0] whole,
	input  logic signed [20:0] micro,
	output logic               frame_valid,
	input  logic               frame_take,
	output lbg_pkg::frame_t    frame
);
	import lbg_pkg::*;

	localparam int DIV_STEPS = 10;
	localparam int DIV_BASE  = 5;
	localparam int TAIL      = DIV_BASE + DIV_STEPS;
	localparam int NSTG      = TAIL + 9;
	localparam int SCALED_W  = $clog2(FULL_SCALE * LED_COUNT + 1);
	localparam int AP_W      = RCP_1K_LO_SH + 7;
	localparam logic [5:0] LAST_IDX = 6'(LED_COUNT - 1);

	logic adv;
	logic [NSTG:1] vld_s;

	logic signed [17:0] base_q;
	logic signed [17:0] top_q;
	logic        [17:0] span_q;
	logic               span_pos_q;

	logic signed [10:0] lo_c;
	logic signed [10:0] hi_c;
	logic signed [19:0] span_c;

	always_comb begin
		lo_c   = cfg.quantity_mode ? cfg.hum_low_limit  : cfg.temp_low_limit;
		hi_c   = cfg.quantity_mode ? cfg.hum_high_limit : cfg.temp_high_limit;
		span_c = (20'(hi_c) - 20'(lo_c)) * 20'sd100;
	end

	always_ff @(posedge clk) begin
		base_q     <= lo_c * 18'sd100;
		top_q      <= hi_c * 18'sd100;
		span_q     <= span_c[17:0];
		span_pos_q <= span_c > 20'sd0;
	end

	assign adv         = !vld_s[NSTG] || frame_take;
	assign in_ready    = adv;
	assign frame_valid = vld_s[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NSTG-1:1], in_valid};
		end
	end

	// reading to hundredths
	logic signed [10:0] whole_s1, whole_s2;
	logic               mneg_s1, mneg_s2;
	logic        [20:0] mabs_s1;
	logic        [41:0] mprod_s2;
	logic signed [17:0] centi_s3;

	logic        [6:0]  mq_c;
	logic signed [17:0] mqs_c;
	logic signed [17:0] w100_c;

	always_comb begin
		mq_c   = mprod_s2[RCP_10K_SH +: 7];
		mqs_c  = mneg_s2 ? -$signed({11'b0, mq_c}) : $signed({11'b0, mq_c});
		w100_c = whole_s2 * 18'sd100;
	end

	// range check and numerator
	logic               zero_s4, full_s4;
	logic        [17:0] diff_s4;
	logic               ovr_s5, ovrf_s5;
	logic        [27:0] num_s5;
	logic signed [18:0] dif_c;

	assign dif_c = 19'(centi_s3) - 19'(base_q);

	always_ff @(posedge clk) begin
		if (adv) begin
			whole_s1 <= whole;
			mneg_s1  <= micro[20];
			mabs_s1  <= micro[20] ? 21'(-micro) : 21'(micro);

			whole_s2 <= whole_s1;
			mneg_s2  <= mneg_s1;
			mprod_s2 <= 42'(mabs_s1) * 42'(RCP_10K);

			centi_s3 <= w100_c + mqs_c;

			zero_s4  <= !span_pos_q || (centi_s3 <= base_q);
			full_s4  <= centi_s3 >= top_q;
			diff_s4  <= dif_c[17:0];

			ovr_s5   <= zero_s4 || full_s4;
			ovrf_s5  <= !zero_s4 && full_s4;
			num_s5   <= (zero_s4 || full_s4) ? 28'd0 : 28'(diff_s4) * 28'd1000;
		end
	end

	// restoring divider, one quotient bit per stage
	logic [27:0] dv_rem_s  [DIV_STEPS];
	logic [9:0]  dv_q_s    [DIV_STEPS];
	logic        dv_ovr_s  [DIV_STEPS];
	logic        dv_ovrf_s [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [27:0] rem_in;
		logic [27:0] trial;
		logic [9:0]  q_in;
		logic        ovr_in;
		logic        ovrf_in;

		if (k == 0) begin : g_first
			assign rem_in  = num_s5;
			assign q_in    = '0;
			assign ovr_in  = ovr_s5;
			assign ovrf_in = ovrf_s5;
		end else begin : g_next
			assign rem_in  = dv_rem_s[k-1];
			assign q_in    = dv_q_s[k-1];
			assign ovr_in  = dv_ovr_s[k-1];
			assign ovrf_in = dv_ovrf_s[k-1];
		end

		assign trial = 28'(span_q) << (DIV_STEPS - 1 - k);

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_ovr_s[k]  <= ovr_in;
				dv_ovrf_s[k] <= ovrf_in;
				if (rem_in >= trial) begin
					dv_rem_s[k] <= rem_in - trial;
					dv_q_s[k]   <= q_in | (10'd1 << (DIV_STEPS - 1 - k));
				end else begin
					dv_rem_s[k] <= rem_in;
					dv_q_s[k]   <= q_in;
				end
			end
		end
	end

	// active LED, position within it, palette segment, blend
	logic [SCALED_W-1:0] scaled_s16, scaled_s17;
	logic [AP_W-1:0]     aprod_s17;
	logic [5:0]          act_s18, act_s19, act_s20, act_s21, act_s22, act_s23, act_s24;
	logic [9:0]          within_s18;
	logic [11:0]         wseg_s19;
	rgb_t                a_s20, a_s21, a_s22, a_s23;
	logic signed [2:0][8:0] d_s20;
	logic [9:0]          frac_s20;
	logic signed [2:0][19:0] p_s21;
	logic [2:0]          neg_s22, neg_s23;
	logic [2:0][17:0]    mag_s22;
	logic [2:0][36:0]    mp_s23;
	rgb_t                part_s24;

	logic [9:0]          level_c;
	logic [6:0]          araw_c;
	logic [5:0]          act_c;
	logic [SCALED_W-1:0] within_c;
	logic [2:0]          segs_c;
	logic [2:0]          seg_c;
	logic [9:0]          frac_c;
	logic                at_end_c;
	rgb_t                pa_c, pb_c;
	logic signed [2:0][8:0] d_c;
	logic [2:0][19:0]    pabs_c;
	logic [2:0][8:0]     q_c;
	logic signed [2:0][8:0] sum_c;

	always_comb begin
		if (dv_ovr_s[DIV_STEPS-1]) begin
			level_c = dv_ovrf_s[DIV_STEPS-1] ? 10'd1000 : 10'd0;
		end else begin
			level_c = dv_q_s[DIV_STEPS-1];
		end

		araw_c   = aprod_s17[RCP_1K_LO_SH +: 7];
		act_c    = (araw_c > {1'b0, LAST_IDX}) ? LAST_IDX : araw_c[5:0];
		within_c = scaled_s17 - SCALED_W'(act_c) * SCALED_W'(FULL_SCALE);

		segs_c = pal_segs(cfg.quantity_mode);
		priority if (wseg_s19 >= 12'd4000) begin
			seg_c  = 3'd4;
			frac_c = 10'(wseg_s19 - 12'd4000);
		end else if (wseg_s19 >= 12'd3000) begin
			seg_c  = 3'd3;
			frac_c = 10'(wseg_s19 - 12'd3000);
		end else if (wseg_s19 >= 12'd2000) begin
			seg_c  = 3'd2;
			frac_c = 10'(wseg_s19 - 12'd2000);
		end else if (wseg_s19 >= 12'd1000) begin
			seg_c  = 3'd1;
			frac_c = 10'(wseg_s19 - 12'd1000);
		end else begin
			seg_c  = 3'd0;
			frac_c = 10'(wseg_s19);
		end
		at_end_c = seg_c >= segs_c;
		pa_c     = pal_color(cfg.quantity_mode, at_end_c ? segs_c : seg_c);
		pb_c     = pal_color(cfg.quantity_mode, seg_c + 3'd1);

		for (int c = 0; c < 3; c++) begin
			d_c[c]    = at_end_c ? 9'sd0
			                     : $signed({1'b0, pb_c[c]}) - $signed({1'b0, pa_c[c]});
			pabs_c[c] = p_s21[c][19] ? 20'(-p_s21[c]) : 20'(p_s21[c]);
			q_c[c]    = {1'b0, mp_s23[c][RCP_1K_SH +: 8]};
			sum_c[c]  = $signed({1'b0, a_s23[c]})
			            + (neg_s23[c] ? -$signed(q_c[c]) : $signed(q_c[c]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			scaled_s16 <= SCALED_W'(level_c) * SCALED_W'(LED_COUNT);

			scaled_s17 <= scaled_s16;
			aprod_s17  <= AP_W'(scaled_s16) * AP_W'(RCP_1K_LO);

			act_s18    <= act_c;
			within_s18 <= within_c[9:0];

			act_s19    <= act_s18;
			wseg_s19   <= 12'(within_s18) * 12'(pal_segs(cfg.quantity_mode));

			act_s20    <= act_s19;
			a_s20      <= pa_c;
			d_s20      <= d_c;
			frac_s20   <= frac_c;

			act_s21    <= act_s20;
			a_s21      <= a_s20;
			for (int c = 0; c < 3; c++) begin
				p_s21[c] <= 20'($signed(d_s20[c])) * $signed({10'b0, frac_s20});
			end

			act_s22    <= act_s21;
			a_s22      <= a_s21;
			for (int c = 0; c < 3; c++) begin
				neg_s22[c] <= p_s21[c][19];
				mag_s22[c] <= pabs_c[c][17:0];
			end

			act_s23    <= act_s22;
			a_s23      <= a_s22;
			neg_s23    <= neg_s22;
			for (int c = 0; c < 3; c++) begin
				mp_s23[c] <= 37'(mag_s22[c]) * 37'(RCP_1K);
			end

			act_s24    <= act_s23;
			for (int c = 0; c < 3; c++) begin
				part_s24[c] <= sum_c[c][7:0];
			end
		end
	end

	assign frame.active = act_s24;
	assign frame.part   = part_s24;

endmodule

[src/lbg_pixel.sv]
`timescale 1ns / 1ps
// lbg_pixel: walks the LEDs of one frame, picks each pixel's color and dims it.
// Depends on lbg_pkg.
module lbg_pixel #(
	parameter int LED_COUNT = lbg_pkg::LED_COUNT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  lbg_pkg::cfg_t   cfg,
	input  logic            frame_valid,
	output logic            frame_take,
	input  lbg_pkg::frame_t frame,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [5:0]      led_index,
	output logic [7:0]      red,
	output logic [7:0]      green,
	output logic [7:0]      blue,
	output logic            last_pixel
);
	import lbg_pkg::*;

	localparam logic [5:0] LAST_IDX = 6'(LED_COUNT - 1);

	frame_t     cur_q;
	logic       cur_v_q;
	logic [5:0] cnt_q;
	logic [4:1] vld_s;
	logic       adv;
	logic       issue;
	logic       done;

	assign adv        = !vld_s[4] || out_ready;
	assign issue      = cur_v_q && adv;
	assign done       = issue && (cnt_q == LAST_IDX);
	assign frame_take = frame_valid && (!cur_v_q || done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			cnt_q   <= '0;
			vld_s   <= '0;
		end else begin
			if (frame_take) begin
				cur_v_q <= 1'b1;
			end else if (done) begin
				cur_v_q <= 1'b0;
			end
			if (issue) begin
				cnt_q <= done ? 6'd0 : cnt_q + 6'd1;
			end
			if (adv) begin
				vld_s <= {vld_s[3:1], issue};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_take) begin
			cur_q <= frame;
		end
	end

	logic [9:0] bright_c;
	rgb_t       col_c;

	always_comb begin
		bright_c = (cfg.brightness_permille > 10'd1000) ? 10'd1000 : cfg.brightness_permille;
		priority if (cnt_q < cur_q.active) begin
			col_c = pal_color(cfg.quantity_mode, pal_segs(cfg.quantity_mode));
		end else if (cnt_q == cur_q.active) begin
			col_c = cur_q.part;
		end else begin
			col_c = '0;
		end
	end

	logic [5:0]       idx_s1, idx_s2, idx_s3, idx_s4;
	logic             last_s1, last_s2, last_s3, last_s4;
	rgb_t             col_s1;
	logic [2:0][17:0] dp_s2;
	logic [2:0][36:0] rp_s3;
	rgb_t             out_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1  <= cnt_q;
			last_s1 <= cnt_q == LAST_IDX;
			col_s1  <= col_c;

			idx_s2  <= idx_s1;
			last_s2 <= last_s1;
			for (int c = 0; c < 3; c++) begin
				dp_s2[c] <= 18'(col_s1[c]) * 18'(bright_c);
			end

			idx_s3  <= idx_s2;
			last_s3 <= last_s2;
			for (int c = 0; c < 3; c++) begin
				rp_s3[c] <= 37'(dp_s2[c]) * 37'(RCP_1K);
			end

			idx_s4  <= idx_s3;
			last_s4 <= last_s3;
			for (int c = 0; c < 3; c++) begin
				out_s4[c] <= rp_s3[c][RCP_1K_SH +: 8];
			end
		end
	end

	assign out_valid  = vld_s[4];
	assign led_index  = idx_s4;
	assign last_pixel = last_s4;
	assign red        = out_s4[0];
	assign green      = out_s4[1];
	assign blue       = out_s4[2];

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking testbench for led_bar_gradient_renderer, with its own pixel predictor.
// Depends on lbg_pkg and led_bar_gradient_renderer; drives readings and register writes.
module tb;
	import lbg_pkg::*;

	localparam int LEDS        = LED_COUNT_DEF;
	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_e;

	typedef struct packed {
		logic [5:0] led;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} pixel_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [31:0]           s_axis_tdata  = '0;  // reading_whole, reading_micro
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [31:0]           m_axis_tdata;        // led_index, red, green, blue
	logic                  m_axis_tlast;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	cfg_t     regs;
	pixel_t   pixels_due[$];
	int       mismatches  = 0;
	int       quiet_cycles = 0;
	int       hold_left   = 0;
	int       rx_phase    = 0;
	int       burst_left  = 0;
	bit       tx_gaps     = 1'b0;
	rx_mode_e rx_mode     = RX_FREE;

	led_bar_gradient_renderer #(.LED_COUNT(LEDS)) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int palette_stop(bit hum, int idx, int ch);
		logic [23:0] c;
		if (hum) begin
			case (idx)
				0:       c = 24'h0000FF;
				1:       c = 24'h4000FF;
				2:       c = 24'h8000FF;
				3:       c = 24'hC000FF;
				default: c = 24'hFF00FF;
			endcase
		end else begin
			case (idx)
				0:       c = 24'h00FF00;
				1:       c = 24'hFFFF00;
				2:       c = 24'hFF8000;
				default: c = 24'hFF0000;
			endcase
		end
		return (ch == 0) ? int'(c[23:16]) : (ch == 1) ? int'(c[15:8]) : int'(c[7:0]);
	endfunction

	function automatic int gradient_shade(bit hum, int level, int ch);
		int segs, scaled, seg, frac, a, b;
		segs   = hum ? 4 : 3;
		scaled = level * segs;
		seg    = scaled / FULL_SCALE;
		frac   = scaled % FULL_SCALE;
		if (seg >= segs)
			return palette_stop(hum, segs, ch);
		a = palette_stop(hum, seg, ch);
		b = palette_stop(hum, seg + 1, ch);
		return a + (b - a) * frac / FULL_SCALE;
	endfunction

	function automatic int fill_permille(int whole, int micro, int lo, int hi);
		longint centi, span, base;
		centi = longint'(whole) * 100 + longint'(micro / 10000);
		span  = (longint'(hi) - longint'(lo)) * 100;
		base  = longint'(lo) * 100;
		if (span <= 0)
			return 0;
		if (centi <= base)
			return 0;
		if (centi >= longint'(hi) * 100)
			return FULL_SCALE;
		return int'((centi - base) * FULL_SCALE / span);
	endfunction

	task automatic render_frame(input logic signed [10:0] whole, input logic signed [20:0] micro);
		bit     hum;
		int     lo, hi, level, scaled, active, led_frac, bright, val;
		int     shade_full[3];
		int     shade_part[3];
		int     dimmed[3];
		pixel_t px;
		hum = regs.quantity_mode;
		lo  = hum ? int'($signed(regs.hum_low_limit)) : int'($signed(regs.temp_low_limit));
		hi  = hum ? int'($signed(regs.hum_high_limit)) : int'($signed(regs.temp_high_limit));
		level  = fill_permille(int'(whole), int'(micro), lo, hi);
		scaled = level * LEDS;
		active = scaled / FULL_SCALE;
		if (active > LEDS - 1)
			active = LEDS - 1;
		led_frac = scaled - active * FULL_SCALE;
		bright = int'(regs.brightness_permille);
		if (bright > FULL_SCALE)
			bright = FULL_SCALE;
		for (int ch = 0; ch < 3; ch++) begin
			shade_full[ch] = gradient_shade(hum, FULL_SCALE, ch);
			shade_part[ch] = gradient_shade(hum, led_frac, ch);
		end
		for (int i = 0; i < LEDS; i++) begin
			for (int ch = 0; ch < 3; ch++) begin
				val = (i < active) ? shade_full[ch] : (i == active) ? shade_part[ch] : 0;
				dimmed[ch] = val * bright / FULL_SCALE;
			end
			px.led   = 6'(i);
			px.red   = 8'(dimmed[0]);
			px.green = 8'(dimmed[1]);
			px.blue  = 8'(dimmed[2]);
			px.last  = (i == LEDS - 1);
			pixels_due.push_back(px);
		end
	endtask

	task automatic send_reading(input int whole, input int micro);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (tx_gaps) begin
				@(negedge clk);
				s_axis_tvalid = 1'b0;
				repeat ($urandom_range(0, 6)) @(negedge clk);
			end
		end
		burst_left = burst_left - 1;
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {micro[20:0], whole[10:0]};
		do @(posedge clk); while (!s_axis_tready);
		render_frame(whole[10:0], micro[20:0]);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = value[CFG_DATA_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_MODE:      regs.quantity_mode       = cfg_data[0];
			REG_TEMP_LOW:  regs.temp_low_limit      = cfg_data;
			REG_TEMP_HIGH: regs.temp_high_limit     = cfg_data;
			REG_HUM_LOW:   regs.hum_low_limit       = cfg_data;
			REG_HUM_HIGH:  regs.hum_high_limit      = cfg_data;
			REG_BRIGHT:    regs.brightness_permille = cfg_data[9:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		burst_left    = 0;
		do @(posedge clk); while (pixels_due.size() != 0);
	endtask

	task automatic random_limits(input bit hum);
		int lo, hi;
		case ($urandom_range(0, 7))
			0: begin
				lo = -1024;
				hi = 1023;
			end
			1: begin
				lo = int'($urandom_range(0, 2047)) - 1024;
				hi = lo;
			end
			2: begin
				lo = int'($urandom_range(0, 2047)) - 1024;
				hi = lo - 1 - int'($urandom_range(0, 20));
				if (hi < -1024)
					hi = -1024;
			end
			default: begin
				lo = int'($urandom_range(0, 2024)) - 1024;
				hi = lo + 1 + int'($urandom_range(0, 30));
				if (hi > 1023)
					hi = 1023;
			end
		endcase
		write_reg(hum ? REG_HUM_LOW : REG_TEMP_LOW, lo);
		write_reg(hum ? REG_HUM_HIGH : REG_TEMP_HIGH, hi);
	endtask

	task automatic random_reading();
		int lo, hi, tmp, whole, micro;
		if ($urandom_range(0, 3) == 0) begin
			whole = int'($urandom_range(0, 2047)) - 1024;
			micro = int'($urandom_range(0, 2097151)) - 1048576;
		end else begin
			lo = regs.quantity_mode ? int'($signed(regs.hum_low_limit))
				: int'($signed(regs.temp_low_limit));
			hi = regs.quantity_mode ? int'($signed(regs.hum_high_limit))
				: int'($signed(regs.temp_high_limit));
			if (lo > hi) begin
				tmp = lo;
				lo  = hi;
				hi  = tmp;
			end
			whole = lo - 1 + int'($urandom_range(0, hi - lo + 2));
			if (whole < -1024)
				whole = -1024;
			if (whole > 1023)
				whole = 1023;
			micro = int'($urandom_range(0, 999999));
			if (whole < 0 || (whole == 0 && $urandom_range(0, 1) == 1))
				micro = -micro;
		end
		send_reading(whole, micro);
	endtask

	task automatic test_reset_settings();
		rx_mode = RX_FREE;
		tx_gaps = 1'b0;
		send_reading(15, 0);
		send_reading(35, 0);
		send_reading(25, 500000);
		send_reading(14, 999999);
		send_reading(34, 999999);
		send_reading(20, -500000);
		send_reading(-1024, -1048576);
		send_reading(1023, 1048575);
		wait_drained();
	endtask

	task automatic test_directed_cases();
		rx_mode = RX_RANDOM;
		tx_gaps = 1'b1;
		write_reg(REG_UNUSED, 2047);
		write_reg(REG_BRIGHT, 1000);
		write_reg(REG_MODE, 1);
		write_reg(REG_HUM_LOW, -1024);
		write_reg(REG_HUM_HIGH, 1023);
		send_reading(0, 0);
		send_reading(-1, 999999);
		send_reading(512, -1);
		wait_drained();
		write_reg(REG_BRIGHT, 1023);
		send_reading(1023, 0);
		wait_drained();
		write_reg(REG_HUM_LOW, 50);
		write_reg(REG_HUM_HIGH, 50);
		send_reading(50, 0);
		send_reading(100, 0);
		wait_drained();
		write_reg(REG_HUM_LOW, 1023);
		write_reg(REG_HUM_HIGH, -1024);
		send_reading(0, 0);
		send_reading(1023, 1048575);
		wait_drained();
		write_reg(REG_MODE, 0);
		write_reg(REG_TEMP_LOW, -1000);
		write_reg(REG_TEMP_HIGH, 1000);
		write_reg(REG_BRIGHT, 0);
		send_reading(500, 0);
		wait_drained();
		write_reg(REG_BRIGHT, 1000);
		send_reading(0, 0);
		send_reading(-999, -999999);
		send_reading(999, 999999);
		wait_drained();
	endtask

	task automatic test_backpressure();
		rx_mode   = RX_RANDOM;
		tx_gaps   = 1'b0;
		hold_left = HOLD_CYCLES;
		for (int n = 0; n < 24; n++)
			random_reading();
		wait_drained();
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 12; phase++) begin
			write_reg(REG_MODE, $urandom_range(0, 1));
			random_limits(1'b0);
			random_limits(1'b1);
			case ($urandom_range(0, 5))
				0:       write_reg(REG_BRIGHT, 0);
				1:       write_reg(REG_BRIGHT, 1000);
				2:       write_reg(REG_BRIGHT, 1023);
				default: write_reg(REG_BRIGHT, $urandom_range(1, 1023));
			endcase
			rx_mode = rx_mode_e'($urandom_range(0, 3));
			tx_gaps = ($urandom_range(0, 2) != 0);
			for (int n = 0; n < 36; n++)
				random_reading();
			wait_drained();
		end
	endtask

	always @(negedge clk) begin
		rx_phase = rx_phase + 1;
		if (hold_left > 0) begin
			hold_left     = hold_left - 1;
			m_axis_tready = 1'b0;
		end else begin
			case (rx_mode)
				RX_FREE:    m_axis_tready = 1'b1;
				RX_RANDOM:  m_axis_tready = ($urandom_range(0, 3) != 0);
				RX_PATTERN: m_axis_tready = ((rx_phase % 7) < 4);
				default:    m_axis_tready = ($urandom_range(0, 9) < 3);
			endcase
		end
	end

	always @(posedge clk) begin
		pixel_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.led   = m_axis_tdata[5:0];
			got.red   = m_axis_tdata[13:6];
			got.green = m_axis_tdata[21:14];
			got.blue  = m_axis_tdata[29:22];
			got.last  = m_axis_tlast;
			if (pixels_due.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected pixel: led %0d rgb %0d %0d %0d last %0b",
						got.led, got.red, got.green, got.blue, got.last);
				mismatches++;
			end else begin
				want = pixels_due.pop_front();
				if (got !== want) begin
					if (mismatches < 10)
						$display({"pixel mismatch: exp led %0d rgb %0d %0d %0d last %0b,",
							" got led %0d rgb %0d %0d %0d last %0b"},
							want.led, want.red, want.green, want.blue, want.last,
							got.led, got.red, got.green, got.blue, got.last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[led_bar_gradient_renderer] ERROR");
			$finish;
		end
	end

	initial begin
		regs.quantity_mode       = 1'b0;
		regs.temp_low_limit      = 11'sd15;
		regs.temp_high_limit     = 11'sd35;
		regs.hum_low_limit       = 11'sd0;
		regs.hum_high_limit      = 11'sd100;
		regs.brightness_permille = 10'd100;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_settings();
		test_directed_cases();
		test_backpressure();
		test_random_settings();
		wait_drained();
		repeat (64) @(posedge clk);
		if (mismatches == 0 && pixels_due.size() == 0)
			$display("[led_bar_gradient_renderer] OK");
		else
			$display("[led_bar_gradient_renderer] ERROR");
		$finish;
	end

endmodule

[sim.f]
src/lbg_pkg.sv
src/lbg_level.sv
src/lbg_pixel.sv
src/led_bar_gradient_renderer.sv
tb/tb.sv
